// ===== src/bcc_pkg.sv =====
`default_nettype none

package bcc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW = 16;
  localparam int unsigned CfgIdxW = 2;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegIdleGap = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLongPress = 2'd1;
  localparam logic [CfgIdxW-1:0] RegDoubleMin = 2'd2;
  localparam logic [CfgIdxW-1:0] RegDoubleMax = 2'd3;

  localparam logic [CfgW-1:0] IdleGapRst = 16'd100;
  localparam logic [CfgW-1:0] LongPressRst = 16'd1000;
  localparam logic [CfgW-1:0] DoubleMinRst = 16'd50;
  localparam logic [CfgW-1:0] DoubleMaxRst = 16'd300;

  // request kinds
  localparam logic ReqSample = 1'b0;
  localparam logic ReqClear = 1'b1;

  // phase codes
  localparam logic [2:0] PhInit = 3'd0;
  localparam logic [2:0] PhPress1 = 3'd1;
  localparam logic [2:0] PhRelease1 = 3'd2;
  localparam logic [2:0] PhWaitRel = 3'd3;
  localparam logic [2:0] PhHold = 3'd4;

  // click results
  localparam logic [1:0] ResNone = 2'd0;
  localparam logic [1:0] ResSingle = 2'd1;
  localparam logic [1:0] ResDouble = 2'd2;
  localparam logic [1:0] ResLong = 2'd3;

  typedef struct packed {
    logic [CfgW-1:0] idle_gap_ms;
    logic [CfgW-1:0] long_press_ms;
    logic [CfgW-1:0] double_min_ms;
    logic [CfgW-1:0] double_max_ms;
  } cfg_t;

  typedef struct packed {
    logic       req_type;
    logic       key_down;
    logic [TimeW-1:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [1:0] click_result;
    logic       result_held;
  } res_t;

endpackage

`default_nettype wire

// ===== src/button_click_classifier.sv =====
// button click classifier
// input channel (in_valid/in_ready): one request per handshake, either a key
// sample (req_type 0, key_down level, now_ms timestamp) or a clear of the
// held result (req_type 1)
// output channel (out_valid/out_ready): one result per request, click_result
// and result_held as they stand after that request
// config port: cfg_we writes cfg_data to register cfg_index at once
// (0 idle gap, 1 long press, 2 double min, 3 double max); the user must
// write only while idle; the block itself does not enforce this
// registers: a request is held in the input register and its result in the
// result register; throughput one request per cycle while out_ready
// holds, set by the single compare-and-update pass between the two registers
// reset: clears the phase, both stored times and the held result, loads the
// default intervals and empties both registers
// stall: a result waits in the output register; one more request is still
// taken into the input register, after which in_ready drops until
// out_ready returns
`default_nettype none

module button_click_classifier (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          req_type,
  input  wire logic                          key_down,
  input  wire logic [bcc_pkg::TimeW-1:0]     now_ms,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         click_result,
  output logic                               result_held,
  input  wire logic                          cfg_we,
  input  wire logic [bcc_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [bcc_pkg::CfgW-1:0]      cfg_data
);

  bcc_pkg::cfg_t cfg;
  bcc_pkg::req_t s1_req;
  bcc_pkg::res_t res_next;
  logic s1_valid;
  logic advance;

  assign advance = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  bcc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bcc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .req      (s1_req),
    .cfg      (cfg),
    .res_next (res_next)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req.req_type <= req_type;
      s1_req.key_down <= key_down;
      s1_req.now_ms <= now_ms;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      click_result <= res_next.click_result;
      result_held <= res_next.result_held;
    end
  end

  a_held_has_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_held |-> click_result != bcc_pkg::ResNone)
    else $error("held result shown without a click");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    advance && s1_req.req_type == bcc_pkg::ReqClear |=>
      out_valid && !result_held && click_result == bcc_pkg::ResNone)
    else $error("clear request did not empty the result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid)
    else $error("registers not empty after reset");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !advance)
    else $error("stalled result overwritten");

endmodule

`default_nettype wire

// ===== src/bcc_cfg_regs.sv =====
`default_nettype none

module bcc_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [bcc_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [bcc_pkg::CfgW-1:0]      cfg_data,
  output bcc_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.idle_gap_ms <= bcc_pkg::IdleGapRst;
      cfg.long_press_ms <= bcc_pkg::LongPressRst;
      cfg.double_min_ms <= bcc_pkg::DoubleMinRst;
      cfg.double_max_ms <= bcc_pkg::DoubleMaxRst;
    end else if (cfg_we) begin
      case (cfg_index)
        bcc_pkg::RegIdleGap: cfg.idle_gap_ms <= cfg_data;
        bcc_pkg::RegLongPress: cfg.long_press_ms <= cfg_data;
        bcc_pkg::RegDoubleMin: cfg.double_min_ms <= cfg_data;
        bcc_pkg::RegDoubleMax: cfg.double_max_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/bcc_core.sv =====
`default_nettype none

module bcc_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire bcc_pkg::req_t req,
  input  wire bcc_pkg::cfg_t cfg,
  output bcc_pkg::res_t      res_next
);

  logic [2:0] phase, phase_next;
  logic [bcc_pkg::TimeW-1:0] press_time, press_time_next;
  logic [bcc_pkg::TimeW-1:0] release_time, release_time_next;
  logic [1:0] held_result, held_result_next;
  logic [bcc_pkg::TimeW-1:0] since_rel, since_press;
  logic [bcc_pkg::TimeW-1:0] idle_gap, long_press, dbl_min, dbl_max;

  // wrapping differences against the stored times
  assign since_rel = req.now_ms - release_time;
  assign since_press = req.now_ms - press_time;
  assign idle_gap = {{(bcc_pkg::TimeW-bcc_pkg::CfgW){1'b0}}, cfg.idle_gap_ms};
  assign long_press = {{(bcc_pkg::TimeW-bcc_pkg::CfgW){1'b0}}, cfg.long_press_ms};
  assign dbl_min = {{(bcc_pkg::TimeW-bcc_pkg::CfgW){1'b0}}, cfg.double_min_ms};
  assign dbl_max = {{(bcc_pkg::TimeW-bcc_pkg::CfgW){1'b0}}, cfg.double_max_ms};

  always_comb begin
    phase_next = phase;
    press_time_next = press_time;
    release_time_next = release_time;
    held_result_next = held_result;
    if (req.req_type == bcc_pkg::ReqClear) begin
      held_result_next = bcc_pkg::ResNone;
      phase_next = bcc_pkg::PhWaitRel;
    end else if (req.key_down) begin
      case (phase)
        bcc_pkg::PhInit: begin
          if (since_rel > idle_gap) begin
            phase_next = bcc_pkg::PhPress1;
            press_time_next = req.now_ms;
          end
        end
        bcc_pkg::PhPress1: begin
          if (since_press > long_press) begin
            held_result_next = bcc_pkg::ResLong;
            phase_next = bcc_pkg::PhHold;
          end
        end
        bcc_pkg::PhRelease1: begin
          if (since_rel > dbl_min && since_rel < dbl_max) begin
            held_result_next = bcc_pkg::ResDouble;
            phase_next = bcc_pkg::PhHold;
            press_time_next = req.now_ms;
          end
        end
        default: ;
      endcase
    end else begin
      case (phase)
        bcc_pkg::PhWaitRel: begin
          phase_next = bcc_pkg::PhInit;
          release_time_next = req.now_ms;
        end
        bcc_pkg::PhPress1: begin
          phase_next = bcc_pkg::PhRelease1;
          release_time_next = req.now_ms;
        end
        bcc_pkg::PhRelease1: begin
          if (since_rel > dbl_max) begin
            held_result_next = bcc_pkg::ResSingle;
            phase_next = bcc_pkg::PhHold;
          end
        end
        default: ;
      endcase
    end
  end

  assign res_next.click_result = held_result_next;
  assign res_next.result_held = (phase_next == bcc_pkg::PhHold);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= bcc_pkg::PhInit;
      press_time <= '0;
      release_time <= '0;
      held_result <= bcc_pkg::ResNone;
    end else if (step) begin
      phase <= phase_next;
      press_time <= press_time_next;
      release_time <= release_time_next;
      held_result <= held_result_next;
    end
  end

endmodule

`default_nettype wire
